[sv/qpa_pkg.sv]
// ============================================================================
// qpa_pkg
// Shared types, widths, the arctangent table and the CORDIC micro-rotation
// step for the pointing-angle pipeline.
// ============================================================================
package qpa_pkg;

    // Algorithm settings
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;

    // Field and datapath widths
    localparam int POS_W  = 32;                 // Q16.16 position
    localparam int QUAT_W = 18;                 // Q1.16 quaternion part
    localparam int NQ_W   = QUAT_W + 1;         // negated quaternion part
    localparam int VW     = POS_W + 1;          // exact difference vector
    localparam int TW     = 2 * NQ_W;           // quaternion products
    localparam int CFW    = 22;                 // rounded rotation coefficient
    localparam int PW     = CFW + VW;           // coefficient times component
    localparam int ACW    = PW + 2;             // sum of three products
    localparam int LW     = 44;                 // local vector component
    localparam int SW     = 6;                  // normalising shift amount
    localparam int CW     = 48;                 // CORDIC x and y
    localparam int AW     = 42;                 // angle accumulator, Q32 degrees
    localparam int AZ_W   = 25;
    localparam int ALT_W  = 24;
    localparam int NORM_MSB = 39;               // a nonzero largest component ends at or above 2^39

    localparam logic [63:0] DEG_PER_RAD_Q26 = 64'd3845054675;

    localparam logic signed [TW-1:0]  RND_C   = TW'(32768);
    localparam logic signed [ACW-1:0] RND_L   = ACW'(16384);
    localparam logic signed [AW-1:0]  HALF_TURN_Q32 = AW'(64'd180 << 32);
    localparam logic signed [AW-1:0]  RND_OUT = AW'(64'd1 << (31 - ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0]  AZ_LIM  = AW'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0]  ALT_LIM = AW'(64'd90 << ANGLE_FRAC_BITS);

    typedef logic signed [CW-1:0] cval_t;

    // Input word, unpacked
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [POS_W-1:0]  peer_pos_z;
        logic signed [POS_W-1:0]  peer_pos_y;
        logic signed [POS_W-1:0]  peer_pos_x;
        logic signed [POS_W-1:0]  own_pos_z;
        logic signed [POS_W-1:0]  own_pos_y;
        logic signed [POS_W-1:0]  own_pos_x;
    } pose_t;

    // Local-frame vector
    typedef struct packed {
        logic signed [LW-1:0] lx;
        logic signed [LW-1:0] ly;
        logic signed [LW-1:0] lz;
    } lvec_t;

    // One CORDIC lane
    typedef struct packed {
        cval_t                x;
        cval_t                y;
        logic signed [AW-1:0] a;
    } lane_t;

    // Azimuth lane plus z gain lane
    typedef struct packed {
        lane_t az;
        lane_t zg;
        logic  z_neg;
        logic  hz_zero;
        logic  deg;
    } az_item_t;

    // Elevation lane with the finished azimuth carried along
    typedef struct packed {
        lane_t                el;
        logic signed [AW-1:0] az_ang;
        logic                 hz_zero;
        logic                 deg;
    } el_item_t;

    typedef struct packed {
        logic [ALT_W-1:0] alt;
        logic [AZ_W-1:0]  az;
        logic             deg;
    } result_t;

    typedef logic [31:0][63:0] atan_table_t;

    // Restoring long division, used only while the table is built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees with 32 fraction bits, from the alternating series
    function automatic atan_table_t build_atan_table();
        atan_table_t tbl;
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] prod;
        tbl    = '0;
        tbl[0] = 64'd45 << 32;
        for (int i = 1; i < 32; i++) begin
            p   = 64'd1 << (62 - i);
            sum = '0;
            k   = '0;
            for (int j = 0; j < 32; j++) begin
                if (p != 64'd0) begin
                    term = udiv64(p, 64'd2 * k + 64'd1);
                    if (!k[0])
                        sum = sum + term;
                    else
                        sum = sum - term;
                    p = p >> (2 * i);
                    k = k + 64'd1;
                end
            end
            prod   = (sum >> 30) * DEG_PER_RAD_Q26;
            tbl[i] = prod >> 26;
        end
        return tbl;
    endfunction

    localparam atan_table_t ATAN_DEG_Q32 = build_atan_table();

    // One vectoring micro-rotation with floor shifts
    function automatic lane_t cordic_step(input lane_t l, input int unsigned i);
        lane_t                o;
        cval_t                xs;
        cval_t                ys;
        logic signed [AW-1:0] da;
        xs = l.x >>> i;
        ys = l.y >>> i;
        da = signed'(ATAN_DEG_Q32[i][AW-1:0]);
        if (!l.y[CW-1]) begin
            o.x = l.x + ys;
            o.y = l.y - xs;
            o.a = l.a + da;
        end
        else begin
            o.x = l.x - ys;
            o.y = l.y + xs;
            o.a = l.a - da;
        end
        return o;
    endfunction

    // Round half up to the output fraction and clamp to +-lim
    function automatic logic signed [AW-1:0] to_out(input logic signed [AW-1:0] q,
                                                    input logic signed [AW-1:0] lim);
        logic signed [AW-1:0] r;
        r = (q + RND_OUT) >>> (32 - ANGLE_FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

endpackage

[sv/qpa_rotate.sv]
// ============================================================================
// qpa_rotate
// Four-stage pipeline: difference vector and quaternion products, rounded
// rotation coefficients, coefficient products, then the local vector.
// ============================================================================
module qpa_rotate (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qpa_pkg::pose_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qpa_pkg::lvec_t       out_data
);

    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   adv;

    logic signed [qpa_pkg::VW-1:0]   v_next  [3];
    logic signed [qpa_pkg::VW-1:0]   v1_reg  [3];
    logic signed [qpa_pkg::VW-1:0]   v2_reg  [3];
    logic signed [qpa_pkg::VW-1:0]   v3_reg  [3];
    logic signed [qpa_pkg::TW-1:0]   t_next  [9];
    logic signed [qpa_pkg::TW-1:0]   t1_reg  [9];
    logic signed [qpa_pkg::TW-1:0]   csum    [9];
    logic signed [qpa_pkg::CFW-1:0]  c_next  [9];
    logic signed [qpa_pkg::CFW-1:0]  c2_reg  [9];
    logic signed [qpa_pkg::PW-1:0]   p_next  [9];
    logic signed [qpa_pkg::PW-1:0]   p3_reg  [9];
    logic signed [qpa_pkg::ACW-1:0]  acc     [3];
    logic signed [qpa_pkg::LW-1:0]   lrow    [3];
    logic signed [qpa_pkg::NQ_W-1:0] qw;
    logic signed [qpa_pkg::NQ_W-1:0] qx;
    logic signed [qpa_pkg::NQ_W-1:0] qy;
    logic signed [qpa_pkg::NQ_W-1:0] qz;
    qpa_pkg::lvec_t                  l_next;
    qpa_pkg::lvec_t                  l4_reg;

    // Advance a stage when it is empty or the one after it advances
    assign adv[NST] = out_ready;
    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NST; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1: exact difference vector, conjugate parts and their products
    always_comb
    begin
        v_next[0] = qpa_pkg::VW'(in_data.peer_pos_x) - qpa_pkg::VW'(in_data.own_pos_x);
        v_next[1] = qpa_pkg::VW'(in_data.peer_pos_y) - qpa_pkg::VW'(in_data.own_pos_y);
        v_next[2] = qpa_pkg::VW'(in_data.peer_pos_z) - qpa_pkg::VW'(in_data.own_pos_z);
        qw = qpa_pkg::NQ_W'(in_data.quat_w);
        qx = -qpa_pkg::NQ_W'(in_data.quat_x);
        qy = -qpa_pkg::NQ_W'(in_data.quat_y);
        qz = -qpa_pkg::NQ_W'(in_data.quat_z);
        t_next[0] = qpa_pkg::TW'(qw) * qpa_pkg::TW'(qx);
        t_next[1] = qpa_pkg::TW'(qw) * qpa_pkg::TW'(qy);
        t_next[2] = qpa_pkg::TW'(qw) * qpa_pkg::TW'(qz);
        t_next[3] = -(qpa_pkg::TW'(qx) * qpa_pkg::TW'(qx));
        t_next[4] = qpa_pkg::TW'(qx) * qpa_pkg::TW'(qy);
        t_next[5] = qpa_pkg::TW'(qx) * qpa_pkg::TW'(qz);
        t_next[6] = -(qpa_pkg::TW'(qy) * qpa_pkg::TW'(qy));
        t_next[7] = qpa_pkg::TW'(qy) * qpa_pkg::TW'(qz);
        t_next[8] = -(qpa_pkg::TW'(qz) * qpa_pkg::TW'(qz));
    end

    // Stage 2: rotation coefficients, rounded half up to 16 fraction bits
    always_comb
    begin
        csum[0] = t1_reg[6] + t1_reg[8];
        csum[1] = t1_reg[4] - t1_reg[2];
        csum[2] = t1_reg[5] + t1_reg[1];
        csum[3] = t1_reg[4] + t1_reg[2];
        csum[4] = t1_reg[3] + t1_reg[8];
        csum[5] = t1_reg[7] - t1_reg[0];
        csum[6] = t1_reg[5] - t1_reg[1];
        csum[7] = t1_reg[7] + t1_reg[0];
        csum[8] = t1_reg[3] + t1_reg[6];
        for (int j = 0; j < 9; j++)
            c_next[j] = qpa_pkg::CFW'((csum[j] + qpa_pkg::RND_C) >>> 16);
    end

    // Stage 3: coefficient times vector component
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                p_next[r*3+c] = qpa_pkg::PW'(c2_reg[r*3+c]) * qpa_pkg::PW'(v2_reg[c]);
    end

    // Stage 4: sum each row, round to Q16.16 and add the vector itself
    always_comb
    begin
        for (int r = 0; r < 3; r++) begin
            acc[r]  = qpa_pkg::ACW'(p3_reg[r*3]) + qpa_pkg::ACW'(p3_reg[r*3+1])
                    + qpa_pkg::ACW'(p3_reg[r*3+2]);
            lrow[r] = qpa_pkg::LW'(v3_reg[r])
                    + qpa_pkg::LW'((acc[r] + qpa_pkg::RND_L) >>> 15);
        end
        l_next.lx = lrow[0];
        l_next.ly = lrow[1];
        l_next.lz = lrow[2];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0]) begin
            v1_reg <= v_next;
            t1_reg <= t_next;
        end
        if (adv[1]) begin
            v2_reg <= v1_reg;
            c2_reg <= c_next;
        end
        if (adv[2]) begin
            v3_reg <= v2_reg;
            p3_reg <= p_next;
        end
        if (adv[3])
            l4_reg <= l_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = l4_reg;

endmodule

[sv/qpa_normalise.sv]
// ============================================================================
// qpa_normalise
// Four-stage pipeline: largest magnitude and zero test, shift search,
// common left shift, then reflection and lane set-up for the CORDIC.
// ============================================================================
module qpa_normalise (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qpa_pkg::lvec_t       in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qpa_pkg::az_item_t    out_data
);

    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   adv;

    logic [qpa_pkg::LW-1:0] ax;
    logic [qpa_pkg::LW-1:0] ay;
    logic [qpa_pkg::LW-1:0] azm;
    logic [qpa_pkg::LW-1:0] mxy;
    logic [qpa_pkg::LW-1:0] m_next;
    logic [qpa_pkg::LW-1:0] m1_reg;
    logic                   deg_next;
    logic                   deg1_reg;
    logic                   deg2_reg;
    logic                   deg3_reg;
    qpa_pkg::lvec_t         l1_reg;
    qpa_pkg::lvec_t         l2_reg;
    qpa_pkg::lvec_t         l3_reg;
    qpa_pkg::lvec_t         ls_next;
    logic [qpa_pkg::SW-1:0] s_next;
    logic [qpa_pkg::SW-1:0] s2_reg;
    logic                   neg;
    qpa_pkg::cval_t         zc;
    qpa_pkg::az_item_t      o_next;
    qpa_pkg::az_item_t      o4_reg;

    // Advance a stage when it is empty or the one after it advances
    assign adv[NST] = out_ready;
    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NST; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1: magnitudes, their maximum and the zero-vector flag
    always_comb
    begin
        ax  = in_data.lx[qpa_pkg::LW-1] ? qpa_pkg::LW'(-in_data.lx) : qpa_pkg::LW'(in_data.lx);
        ay  = in_data.ly[qpa_pkg::LW-1] ? qpa_pkg::LW'(-in_data.ly) : qpa_pkg::LW'(in_data.ly);
        azm = in_data.lz[qpa_pkg::LW-1] ? qpa_pkg::LW'(-in_data.lz) : qpa_pkg::LW'(in_data.lz);
        mxy = (ax > ay) ? ax : ay;
        m_next   = (azm > mxy) ? azm : mxy;
        deg_next = (in_data.lx == '0) && (in_data.ly == '0) && (in_data.lz == '0);
    end

    // Stage 2: shift that brings the top set bit up to the normalised position
    always_comb
    begin
        s_next = '0;
        for (int b = 0; b < qpa_pkg::NORM_MSB; b++)
            if (m1_reg[b])
                s_next = qpa_pkg::SW'(qpa_pkg::NORM_MSB - b);
        if (|m1_reg[qpa_pkg::LW-1:qpa_pkg::NORM_MSB])
            s_next = '0;
    end

    // Stage 3: common left shift of all three components
    always_comb
    begin
        ls_next.lx = l2_reg.lx <<< s2_reg;
        ls_next.ly = l2_reg.ly <<< s2_reg;
        ls_next.lz = l2_reg.lz <<< s2_reg;
    end

    // Stage 4: reflect negative x through the origin, set up both lanes
    always_comb
    begin
        neg = l3_reg.lx[qpa_pkg::LW-1];
        zc  = qpa_pkg::CW'(l3_reg.lz);
        o_next.az.x = neg ? -qpa_pkg::CW'(l3_reg.lx) : qpa_pkg::CW'(l3_reg.lx);
        o_next.az.y = neg ? -qpa_pkg::CW'(l3_reg.ly) : qpa_pkg::CW'(l3_reg.ly);
        if (!neg)
            o_next.az.a = '0;
        else if (!l3_reg.ly[qpa_pkg::LW-1])
            o_next.az.a = qpa_pkg::HALF_TURN_Q32;
        else
            o_next.az.a = -qpa_pkg::HALF_TURN_Q32;
        o_next.zg.x    = zc[qpa_pkg::CW-1] ? -zc : zc;
        o_next.zg.y    = '0;
        o_next.zg.a    = '0;
        o_next.z_neg   = zc[qpa_pkg::CW-1];
        o_next.hz_zero = (l3_reg.lx == '0) && (l3_reg.ly == '0);
        o_next.deg     = deg3_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0]) begin
            l1_reg   <= in_data;
            m1_reg   <= m_next;
            deg1_reg <= deg_next;
        end
        if (adv[1]) begin
            l2_reg   <= l1_reg;
            s2_reg   <= s_next;
            deg2_reg <= deg1_reg;
        end
        if (adv[2]) begin
            l3_reg   <= ls_next;
            deg3_reg <= deg2_reg;
        end
        if (adv[3])
            o4_reg <= o_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = o4_reg;

endmodule

[sv/qpa_az_cordic.sv]
// ============================================================================
// qpa_az_cordic
// Vectoring CORDIC, one micro-rotation per stage, on two lanes at once:
// the horizontal vector for azimuth and (|z|, 0) for the gain-scaled z.
// ============================================================================
module qpa_az_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qpa_pkg::az_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qpa_pkg::az_item_t    out_data
);

    localparam int NST = qpa_pkg::CORDIC_STEPS;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   adv;

    qpa_pkg::az_item_t st_reg  [NST];
    qpa_pkg::az_item_t st_next [NST];

    // Advance a stage when it is empty or the one after it advances
    assign adv[NST] = out_ready;
    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NST; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // One micro-rotation per stage on both lanes
    generate
        for (g = 0; g < NST; g++) begin : g_step
            if (g == 0) begin : g_first
                always_comb
                begin
                    st_next[g]    = in_data;
                    st_next[g].az = qpa_pkg::cordic_step(in_data.az, g);
                    st_next[g].zg = qpa_pkg::cordic_step(in_data.zg, g);
                end
            end
            else begin : g_rest
                always_comb
                begin
                    st_next[g]    = st_reg[g-1];
                    st_next[g].az = qpa_pkg::cordic_step(st_reg[g-1].az, g);
                    st_next[g].zg = qpa_pkg::cordic_step(st_reg[g-1].zg, g);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[g])
                    st_reg[g] <= st_next[g];
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = st_reg[NST-1];

endmodule

[sv/qpa_el_cordic.sv]
// ============================================================================
// qpa_el_cordic
// Elevation stage: restores the sign of the gain-scaled z, runs the
// vectoring CORDIC on (range, z) and rounds and clamps both angles.
// ============================================================================
module qpa_el_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qpa_pkg::az_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qpa_pkg::result_t     out_data
);

    localparam int CS  = qpa_pkg::CORDIC_STEPS;
    localparam int NST = CS + 2;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   adv;

    qpa_pkg::el_item_t     st_reg  [CS+1];
    qpa_pkg::el_item_t     st_next [CS+1];
    qpa_pkg::result_t      res_next;
    qpa_pkg::result_t      res_reg;
    logic signed [qpa_pkg::AW-1:0] az_full;
    logic signed [qpa_pkg::AW-1:0] alt_full;

    // Advance a stage when it is empty or the one after it advances
    assign adv[NST] = out_ready;
    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    always_comb
    begin
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NST; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Set up (range, signed gain-scaled z); keep the azimuth angle alongside
    always_comb
    begin
        st_next[0].el.x    = in_data.az.x;
        st_next[0].el.y    = in_data.z_neg ? -in_data.zg.x : in_data.zg.x;
        st_next[0].el.a    = '0;
        st_next[0].az_ang  = in_data.az.a;
        st_next[0].hz_zero = in_data.hz_zero;
        st_next[0].deg     = in_data.deg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            st_reg[0] <= st_next[0];
    end

    // One micro-rotation per stage
    generate
        for (g = 1; g <= CS; g++) begin : g_step
            always_comb
            begin
                st_next[g]    = st_reg[g-1];
                st_next[g].el = qpa_pkg::cordic_step(st_reg[g-1].el, g - 1);
            end

            always_ff @(posedge clk)
            begin
                if (adv[g])
                    st_reg[g] <= st_next[g];
            end
        end
    endgenerate

    // Round, clamp and negate; force zeros for the degenerate cases
    always_comb
    begin
        az_full  = qpa_pkg::to_out(st_reg[CS].az_ang, qpa_pkg::AZ_LIM);
        alt_full = -qpa_pkg::to_out(st_reg[CS].el.a, qpa_pkg::ALT_LIM);
        res_next.deg = st_reg[CS].deg;
        res_next.az  = (st_reg[CS].deg || st_reg[CS].hz_zero) ? '0
                                                             : az_full[qpa_pkg::AZ_W-1:0];
        res_next.alt = st_reg[CS].deg ? '0 : alt_full[qpa_pkg::ALT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[NST-1])
            res_reg <= res_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = res_reg;

endmodule

[sv/quaternion_pointing_angles.sv]
// ============================================================================
// quaternion_pointing_angles
// Azimuth and negated elevation of a target seen from an oriented platform.
// ============================================================================
// One pose word (own and target position, own orientation quaternion) goes in
// per cycle and one angle word comes out per cycle while the output is not
// stalled. The pipeline has four stages of rotation, four of normalisation,
// CORDIC_STEPS shared azimuth / z-gain micro-rotations, CORDIC_STEPS
// elevation micro-rotations plus a set-up and an output stage. Every stage
// holds its own valid bit and advances when it is empty or its successor
// advances, so bubbles are squeezed out under back-pressure and a new word is
// taken whenever any stage ahead has room. Azimuth is Q8.16 and negated
// elevation Q7.16 degrees; a zero vector raises degenerate with zero angles.
// ============================================================================
module quaternion_pointing_angles (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // own_pos_x, own_pos_y, own_pos_z, peer_pos_x, peer_pos_y, peer_pos_z,
    // quat_w, quat_x, quat_y, quat_z
    input  logic [263:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // azimuth, negated elevation, zero padding
    output logic [55:0]  m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser
);

    qpa_pkg::pose_t    pose;
    logic              rot_valid;
    logic              rot_ready;
    qpa_pkg::lvec_t    rot_data;
    logic              norm_valid;
    logic              norm_ready;
    qpa_pkg::az_item_t norm_data;
    logic              azc_valid;
    logic              azc_ready;
    qpa_pkg::az_item_t azc_data;
    qpa_pkg::result_t  res;

    // Unpack the input word
    assign pose.own_pos_x  = s_axis_tdata[31:0];
    assign pose.own_pos_y  = s_axis_tdata[63:32];
    assign pose.own_pos_z  = s_axis_tdata[95:64];
    assign pose.peer_pos_x = s_axis_tdata[127:96];
    assign pose.peer_pos_y = s_axis_tdata[159:128];
    assign pose.peer_pos_z = s_axis_tdata[191:160];
    assign pose.quat_w     = s_axis_tdata[209:192];
    assign pose.quat_x     = s_axis_tdata[227:210];
    assign pose.quat_y     = s_axis_tdata[245:228];
    assign pose.quat_z     = s_axis_tdata[263:246];

    qpa_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (pose),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    qpa_normalise u_normalise (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    qpa_az_cordic u_az_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (azc_valid),
        .out_ready (azc_ready),
        .out_data  (azc_data)
    );

    qpa_el_cordic u_el_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (azc_valid),
        .in_ready  (azc_ready),
        .in_data   (azc_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // Pack the output word
    assign m_axis_tdata = {7'b0, res.alt, res.az};
    assign m_axis_tuser = res.deg;

`ifndef ASSERT_OFF
    // A degenerate word carries zero angles
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser)
        |-> (m_axis_tdata[qpa_pkg::AZ_W + qpa_pkg::ALT_W - 1:0] == '0))
        else $error("degenerate word with non-zero angles");

    // An empty output stage lets the whole ready chain open
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    // A word taken at the output comes with ready at the input
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output word drains");
`endif

endmodule

[tb/quaternion_pointing_angles_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// quaternion_pointing_angles_tb
// Checks pointing angles against an in-bench predictor of the fixed-point
// rotation and CORDIC stages. Directed poses cover the range limits, zero
// vectors, the vertical and negative-x cases and non-unit quaternions; random
// poses follow, with bursty input, receiver stalls and one long hold-off.
// ============================================================================
module quaternion_pointing_angles_tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic         m_axis_tuser;

    typedef struct {
        logic [qpa_pkg::AZ_W-1:0]  az;
        logic [qpa_pkg::ALT_W-1:0] alt;
        logic                      deg;
    } angles_t;

    angles_t     angles_due[$];
    longint      atan_q32[32];
    int          err_count;
    int          hold_reqs;
    bit          sender_on;

    quaternion_pointing_angles i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Arctangent table in Q32 degrees from the alternating series
    function automatic void fill_atan();
        longint unsigned p;
        longint unsigned sum;
        longint unsigned k;
        atan_q32[0] = longint'(64'd45 << 32);
        for (int i = 1; i < 32; i++)
        begin
            p   = 64'd1 << (62 - i);
            sum = 0;
            k   = 0;
            while (p != 0)
            begin
                if (!k[0])
                    sum += p / (2 * k + 1);
                else
                    sum -= p / (2 * k + 1);
                p = p >> (2 * i);
                k++;
            end
            atan_q32[i] = longint'(((sum >> 30) * 64'd3845054675) >> 26);
        end
    endfunction

    // Vectoring rotations with floor shifts; returns the scaled magnitude
    function automatic longint vector_rotate(longint x, longint y, output longint ang);
        longint xs;
        longint ys;
        ang = 0;
        for (int i = 0; i < qpa_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; ang += atan_q32[i];
            end
            else
            begin
                x -= ys; y += xs; ang -= atan_q32[i];
            end
        end
        return x;
    endfunction

    function automatic longint round_clamp(longint q, longint lim);
        longint r;
        r = (q + (longint'(1) << (31 - qpa_pkg::ANGLE_FRAC_BITS)))
            >>> (32 - qpa_pkg::ANGLE_FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic longint rotate_row(longint a, longint b, longint c, longint vx,
                                          longint vy, longint vz, longint self_c);
        longint acc;
        acc = ((a + 32768) >>> 16) * vx + ((b + 32768) >>> 16) * vy
            + ((c + 32768) >>> 16) * vz;
        return self_c + ((acc + 16384) >>> 15);
    endfunction

    // Predict the angle word for one pose
    function automatic angles_t predict_angles(qpa_pkg::pose_t p);
        angles_t res;
        longint vx, vy, vz, w, ix, iy, iz;
        longint t2, t3, t4, t5, t6, t7, t8, t9, t10;
        longint lx, ly, lz, r, zk, ang, az, alt, base;
        longint unsigned m;
        vx = longint'(p.peer_pos_x) - longint'(p.own_pos_x);
        vy = longint'(p.peer_pos_y) - longint'(p.own_pos_y);
        vz = longint'(p.peer_pos_z) - longint'(p.own_pos_z);
        w  = p.quat_w;
        ix = -longint'(p.quat_x);
        iy = -longint'(p.quat_y);
        iz = -longint'(p.quat_z);
        t2 = w * ix; t3 = w * iy; t4 = w * iz;
        t5 = -ix * ix; t6 = ix * iy; t7 = ix * iz;
        t8 = -iy * iy; t9 = iy * iz; t10 = -iz * iz;
        lx = rotate_row(t8 + t10, t6 - t4, t7 + t3, vx, vy, vz, vx);
        ly = rotate_row(t6 + t4, t5 + t10, t9 - t2, vx, vy, vz, vy);
        lz = rotate_row(t7 - t3, t9 + t2, t5 + t8, vx, vy, vz, vz);
        res.deg = 1'b0;
        if (lx == 0 && ly == 0 && lz == 0)
        begin
            res.az  = '0;
            res.alt = '0;
            res.deg = 1'b1;
            return res;
        end
        m = (lx < 0) ? -lx : lx;
        if (((ly < 0) ? -ly : ly) > m)
            m = (ly < 0) ? -ly : ly;
        if (((lz < 0) ? -lz : lz) > m)
            m = (lz < 0) ? -lz : lz;
        // Normalise so the largest component reaches at least 2^39
        while (m < (64'd1 << qpa_pkg::NORM_MSB))
        begin
            m = m << 1; lx = lx <<< 1; ly = ly <<< 1; lz = lz <<< 1;
        end
        az = 0;
        if (lx == 0 && ly == 0)
            r = 0;
        else
        begin
            base = 0;
            if (lx < 0)
            begin
                base = (ly >= 0) ? (longint'(180) << 32) : -(longint'(180) << 32);
                lx = -lx; ly = -ly;
            end
            r  = vector_rotate(lx, ly, ang);
            az = round_clamp(base + ang, longint'(180) << qpa_pkg::ANGLE_FRAC_BITS);
        end
        zk = vector_rotate((lz < 0) ? -lz : lz, 0, ang);
        if (lz < 0)
            zk = -zk;
        void'(vector_rotate(r, zk, ang));
        alt = -round_clamp(ang, longint'(90) << qpa_pkg::ANGLE_FRAC_BITS);
        res.az  = az[qpa_pkg::AZ_W-1:0];
        res.alt = alt[qpa_pkg::ALT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    // Offer one pose word; hold it until taken, drop valid during a gap
    task automatic send_pose(qpa_pkg::pose_t p);
        if (!sender_on)
        begin
            s_axis_tvalid <= 1'b0;
            while (!sender_on)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        angles_due.push_back(predict_angles(p));
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [17:0] rand_quat_part();
        case ($urandom_range(0, 7))
            0:       return 18'sd65536;
            1:       return -18'sd65536;
            2:       return 18'd0;
            3:       return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic qpa_pkg::pose_t rand_pose();
        qpa_pkg::pose_t p;
        p.own_pos_x  = rand_pos(); p.own_pos_y  = rand_pos(); p.own_pos_z  = rand_pos();
        p.peer_pos_x = rand_pos(); p.peer_pos_y = rand_pos(); p.peer_pos_z = rand_pos();
        // Frequently coincide in x and y, in z, or on all three axes
        if ($urandom_range(0, 9) == 0)
        begin
            p.peer_pos_x = p.own_pos_x; p.peer_pos_y = p.own_pos_y;
        end
        if ($urandom_range(0, 14) == 0)
            p.peer_pos_z = p.own_pos_z;
        p.quat_w = rand_quat_part(); p.quat_x = rand_quat_part();
        p.quat_y = rand_quat_part(); p.quat_z = rand_quat_part();
        return p;
    endfunction

    function automatic qpa_pkg::pose_t make_pose(logic [31:0] dx, logic [31:0] dy,
                                                 logic [31:0] dz,
                                                 logic [17:0] qw, logic [17:0] qx,
                                                 logic [17:0] qy, logic [17:0] qz);
        qpa_pkg::pose_t p;
        p.own_pos_x = '0; p.own_pos_y = '0; p.own_pos_z = '0;
        p.peer_pos_x = dx; p.peer_pos_y = dy; p.peer_pos_z = dz;
        p.quat_w = qw; p.quat_x = qx; p.quat_y = qy; p.quat_z = qz;
        return p;
    endfunction

    // Pause the sender until every expected word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        qpa_pkg::pose_t p;
        logic [17:0] one;
        logic [17:0] zq;
        one = 18'sd65536;
        zq  = 18'd0;
        send_pose(make_pose(0, 0, 0, one, zq, zq, zq));                 // zero vector
        send_pose(make_pose(32'h10000, 0, 0, one, zq, zq, zq));
        send_pose(make_pose(-32'sh10000, 0, 0, one, zq, zq, zq));       // negative x, y zero
        send_pose(make_pose(-32'sh10000, -32'sh1, 0, one, zq, zq, zq));
        send_pose(make_pose(-32'sh10000, 32'sh1, 0, one, zq, zq, zq));
        send_pose(make_pose(0, 32'h10000, 0, one, zq, zq, zq));
        send_pose(make_pose(0, -32'sh10000, 0, one, zq, zq, zq));
        send_pose(make_pose(0, 0, 32'h10000, one, zq, zq, zq));        // straight up
        send_pose(make_pose(0, 0, -32'sh10000, one, zq, zq, zq));       // straight down
        send_pose(make_pose(0, 0, 1, one, zq, zq, zq));
        send_pose(make_pose(32'h10000, 32'h10000, 32'h10000, zq, one, zq, zq));
        send_pose(make_pose(32'h10000, 32'h20000, 0, zq, zq, zq, one));
        send_pose(make_pose(32'h10000, 0, 0, -one, zq, zq, zq));
        send_pose(make_pose(32'h10000, 5, 7, zq, zq, zq, zq));          // null quaternion
        send_pose(make_pose(32'h10000, 5, 7, one, one, one, one));      // non-unit
        send_pose(make_pose(32'h10000, 5, 7, -one, -one, -one, -one));
        send_pose(make_pose(32'h10000, 5, 7, 18'h1ffff, 18'h20000, 18'h3ffff, 18'h1));
        // Extreme positions give the widest difference
        p = make_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, one, one, one, one);
        p.own_pos_x = 32'h8000_0000; p.own_pos_y = 32'h8000_0000; p.own_pos_z = 32'h8000_0000;
        send_pose(p);
        p.quat_w = 18'h20000; p.quat_x = 18'h20000; p.quat_y = 18'h1ffff; p.quat_z = 18'h20000;
        send_pose(p);
        p = make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, one, zq, zq, zq);
        p.own_pos_x = 32'h7fff_ffff; p.own_pos_y = 32'h7fff_ffff; p.own_pos_z = 32'h7fff_ffff;
        send_pose(p);
        p = make_pose(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 18'h3ffff, 18'h3ffff,
                      18'h3ffff, 18'h3ffff);
        send_pose(p);
        send_pose(make_pose(1, 0, 0, 18'h20000, 18'h20000, 18'h20000, 18'h20000));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_pose(rand_pose());
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_reqs++;
        test_random(120);
        wait_drained();
    endtask

    // Sender bursts and gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            sender_on <= 1'b1;
        else if ($urandom_range(0, 15) == 0)
            sender_on <= ~sender_on | ($urandom_range(0, 3) == 0);
    end

    // Receiver: stall pattern, long hold-off on request
    initial
    begin
        int phase;
        int hold_seen;
        int hold_left;
        phase     = 0;
        hold_seen = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if ((phase % 1000) < 300)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
        end
    end

    // Check each accepted angle word against the oldest prediction
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (angles_due.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata, 0);
            else
            begin
                want = angles_due.pop_front();
                if (m_axis_tdata[qpa_pkg::AZ_W-1:0] !== want.az)
                    report_mismatch("azimuth", m_axis_tdata[qpa_pkg::AZ_W-1:0], want.az);
                if (m_axis_tdata[qpa_pkg::AZ_W+qpa_pkg::ALT_W-1:qpa_pkg::AZ_W] !== want.alt)
                    report_mismatch("altitude",
                                    m_axis_tdata[qpa_pkg::AZ_W+qpa_pkg::ALT_W-1:qpa_pkg::AZ_W],
                                    want.alt);
                if (m_axis_tdata[55:qpa_pkg::AZ_W+qpa_pkg::ALT_W] !== '0)
                    report_mismatch("padding", m_axis_tdata[55:qpa_pkg::AZ_W+qpa_pkg::ALT_W],
                                    0);
                if (m_axis_tuser !== want.deg)
                    report_mismatch("degenerate", m_axis_tuser, want.deg);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("quaternion_pointing_angles test failed");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        err_count     = 0;
        hold_reqs     = 0;
        fill_atan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_backpressure();
        test_random(1300);
        wait_drained();
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("quaternion_pointing_angles test passed");
        else
            $display("quaternion_pointing_angles test failed");
        $finish;
    end
endmodule

[quaternion_pointing_angles.f]
sv/qpa_pkg.sv
sv/qpa_rotate.sv
sv/qpa_normalise.sv
sv/qpa_az_cordic.sv
sv/qpa_el_cordic.sv
sv/quaternion_pointing_angles.sv
tb/quaternion_pointing_angles_tb.sv
